// ----- design/u16u8_pkg.sv -----
package u16u8_pkg;

	// queue between the classifier and the byte serializer
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [15:0] ONE_BYTE_LIMIT  = 16'h0080;
	localparam logic [15:0] TWO_BYTE_LIMIT  = 16'h0800;
	localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;

	// 0x10000 - (0xD800 << 10) - 0xDC00, low 26 bits; only cp[25:0] reaches a byte
	localparam logic [25:0] PAIR_BIAS = 26'h0A02400;

	localparam logic [7:0] LEAD_2 = 8'hC0;
	localparam logic [7:0] LEAD_3 = 8'hE0;
	localparam logic [7:0] LEAD_4 = 8'hF0;
	localparam logic [7:0] CONT   = 8'h80;

	// one encoded sequence: bytes[0] goes out first, last_idx is the final byte
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
	} seq_t;

endpackage

// ----- design/utf16_to_utf8_encoder.sv -----
// UTF-16 to UTF-8 encoder. Each input word is one code unit (or, with tlast set, an end of
// string marker that yields a single zero byte and drops any held high surrogate). Output
// words are single UTF-8 bytes, tlast marking the final byte of each input word. Input is
// taken in any cycle the two-entry queue has room; the output side sends one byte per
// cycle while the receiver is ready, so an input word yields 0 to 4 bytes (1 for ASCII
// and end of string, 2 below 0x800, 3 for other units, 4 for a completed surrogate pair,
// 0 for a held high surrogate), and that one-byte-per-cycle serializer sets the sustained
// rate. The first byte of a word passes the queue and then the output register.
module utf16_to_utf8_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] code_unit
	input  logic        s_axis_tlast,  // string_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
	output logic        m_axis_tlast   // last_byte
);
	import u16u8_pkg::*;

	logic push;
	seq_t push_seq;
	logic full;
	logic pop;
	logic empty;
	seq_t head;

	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.code_unit  (s_axis_tdata),
		.string_end (s_axis_tlast),
		.fifo_full  (full),
		.push       (push),
		.push_seq   (push_seq)
	);

	u16u8_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_seq (push_seq),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	u16u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.last_byte (m_axis_tlast)
	);

endmodule

// ----- design/u16u8_front.sv -----
module u16u8_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       code_unit,
	input  logic              string_end,
	input  logic              fifo_full,
	output logic              push,
	output u16u8_pkg::seq_t   push_seq
);
	import u16u8_pkg::*;

	logic [15:0] held_high_q;
	logic        pending_q;
	logic        accept;
	logic        is_high;
	logic [25:0] cp;

	assign in_ready = !fifo_full;
	assign accept   = in_valid && in_ready;
	assign is_high  = (code_unit >= HIGH_SURR_FIRST) && (code_unit <= HIGH_SURR_LAST);
	assign cp       = {held_high_q, 10'd0} + {10'd0, code_unit} + PAIR_BIAS;

	always_comb begin
		push_seq = '0;
		push     = 1'b0;
		if (string_end) begin
			push_seq.last_idx = 2'd0;
			push              = accept;
		end else if (pending_q) begin
			push_seq.bytes[0] = LEAD_4 | cp[25:18];
			push_seq.bytes[1] = CONT | {2'b00, cp[17:12]};
			push_seq.bytes[2] = CONT | {2'b00, cp[11:6]};
			push_seq.bytes[3] = CONT | {2'b00, cp[5:0]};
			push_seq.last_idx = 2'd3;
			push              = accept;
		end else if (code_unit < ONE_BYTE_LIMIT) begin
			push_seq.bytes[0] = code_unit[7:0];
			push_seq.last_idx = 2'd0;
			push              = accept;
		end else if (code_unit < TWO_BYTE_LIMIT) begin
			push_seq.bytes[0] = LEAD_2 | {3'b000, code_unit[10:6]};
			push_seq.bytes[1] = CONT | {2'b00, code_unit[5:0]};
			push_seq.last_idx = 2'd1;
			push              = accept;
		end else if (!is_high) begin
			push_seq.bytes[0] = LEAD_3 | {4'b0000, code_unit[15:12]};
			push_seq.bytes[1] = CONT | {2'b00, code_unit[11:6]};
			push_seq.bytes[2] = CONT | {2'b00, code_unit[5:0]};
			push_seq.last_idx = 2'd2;
			push              = accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_high_q <= '0;
			pending_q   <= 1'b0;
		end else if (accept) begin
			// a lone high surrogate is held and produces nothing yet
			if (!string_end && !pending_q && is_high) begin
				held_high_q <= code_unit;
				pending_q   <= 1'b1;
			end else begin
				held_high_q <= '0;
				pending_q   <= 1'b0;
			end
		end
	end

endmodule

// ----- design/u16u8_fifo.sv -----
module u16u8_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u16u8_pkg::seq_t   push_seq,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output u16u8_pkg::seq_t   head
);
	import u16u8_pkg::*;

	seq_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_seq;
		end
	end

	// depth is a power of two, so the pointers wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/u16u8_back.sv -----
module u16u8_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  u16u8_pkg::seq_t   head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              last_byte
);
	import u16u8_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       take;
	logic       at_last;

	assign take      = !out_valid_q || out_ready;
	assign at_last   = (idx_q == head.last_idx);
	assign pop       = take && !empty && at_last;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

	always_ff @(posedge clk) begin
		if (take && !empty) begin
			out_byte_q <= head.bytes[idx_q];
			last_q     <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (take) begin
			out_valid_q <= !empty;
			if (!empty) begin
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

endmodule

// ----- tb/sv/tb_utf16_to_utf8_encoder.sv -----
`timescale 1ns / 100ps

module tb_utf16_to_utf8_encoder;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [15:0] ASCII_TOP = 16'h007F;
	localparam logic [15:0] TWO_BYTE_FIRST = 16'h0080;
	localparam logic [15:0] TWO_BYTE_TOP = 16'h07FF;
	localparam logic [15:0] THREE_BYTE_FIRST = 16'h0800;
	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_TOP = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST = 16'hDC00;
	localparam logic [15:0] LOW_TOP = 16'hDFFF;
	// offset that folds a high/low pair into one code point, modulo 2^32
	localparam logic [31:0] PAIR_OFFSET = 32'h0001_0000 - (32'h0000_D800 << 10) - 32'h0000_DC00;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} utf8_byte_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // [15:0] code_unit
	logic        s_axis_tlast;  // string_end
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;  // [7:0] out_byte
	logic        m_axis_tlast;  // last_byte

	utf8_byte_t  utf8_expected[$];
	utf8_byte_t  next_byte;
	logic [15:0] held_high;
	logic        high_held;
	int          tx_idle_pct;
	int          rx_stall_pct;
	int          hold_left;
	int          errors;
	int          cycle_count;

	utf16_to_utf8_encoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #6 clk = ~clk;

	function automatic void push_byte(input logic [31:0] value, input logic last);
		utf8_byte_t b;
		b.data = value[7:0];
		b.last = last;
		utf8_expected.insert(utf8_expected.size(), b);
	endfunction

	// expected utf-8 bytes for one accepted word
	function automatic void encode_word(input logic [15:0] unit, input logic string_end);
		logic [31:0] cp;
		logic [31:0] u;
		u = {16'h0000, unit};
		if (string_end) begin
			held_high = '0;
			high_held = 1'b0;
			push_byte(32'h0, 1'b1);
		end else if (high_held) begin
			cp = ({16'h0000, held_high} << 10) + u + PAIR_OFFSET;
			held_high = '0;
			high_held = 1'b0;
			push_byte(32'hF0 | (cp >> 18), 1'b0);
			push_byte(32'h80 | ((cp >> 12) & 32'h3F), 1'b0);
			push_byte(32'h80 | ((cp >> 6) & 32'h3F), 1'b0);
			push_byte(32'h80 | (cp & 32'h3F), 1'b1);
		end else if (unit <= ASCII_TOP) begin
			push_byte(u, 1'b1);
		end else if (unit <= TWO_BYTE_TOP) begin
			push_byte(32'hC0 | (u >> 6), 1'b0);
			push_byte(32'h80 | (u & 32'h3F), 1'b1);
		end else if (unit < HIGH_FIRST || unit > HIGH_TOP) begin
			push_byte(32'hE0 | (u >> 12), 1'b0);
			push_byte(32'h80 | ((u >> 6) & 32'h3F), 1'b0);
			push_byte(32'h80 | (u & 32'h3F), 1'b1);
		end else begin
			held_high = unit;
			high_held = 1'b1;
		end
	endfunction

	task automatic send_word(input logic [15:0] unit, input logic string_end);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			s_axis_tdata = 16'($urandom);
			s_axis_tlast = 1'($urandom);
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = unit;
		s_axis_tlast = string_end;
		do @(posedge clk); while (!s_axis_tready);
		encode_word(unit, string_end);
	endtask

	task automatic send_unit(input logic [15:0] unit);
		send_word(unit, 1'b0);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (utf8_expected.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_single_units();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		send_unit(16'h0000);
		send_unit(ASCII_TOP);
		send_unit(TWO_BYTE_FIRST);
		send_unit(TWO_BYTE_TOP);
		send_unit(THREE_BYTE_FIRST);
		send_unit(HIGH_FIRST - 16'h1);
		send_unit(16'hFFFF);
		// lone low surrogate encodes as three bytes
		send_unit(LOW_FIRST);
		send_unit(LOW_TOP);
	endtask

	task automatic test_surrogates();
		send_unit(HIGH_FIRST);
		send_unit(LOW_FIRST);
		send_unit(HIGH_TOP);
		send_unit(LOW_TOP);
		// second unit taken as low half even when it is not one
		send_unit(16'hD9AB);
		send_unit(16'h0041);
		send_unit(16'hDA00);
		send_unit(HIGH_TOP);
		send_unit(HIGH_FIRST);
		send_unit(16'hFFFF);
	endtask

	task automatic test_string_end();
		send_word(16'h0000, 1'b1);
		// pending high surrogate is dropped by end of string
		send_unit(HIGH_TOP);
		send_word(16'hFFFF, 1'b1);
		send_unit(16'h0055);
		send_word(16'hAAAA, 1'b1);
		wait_drained();
	endtask

	task automatic test_input_stall();
		int i;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		@(posedge clk);
		hold_left = 80;
		for (i = 0; i < 16; i++) begin
			send_unit(16'($urandom_range(THREE_BYTE_FIRST, HIGH_FIRST - 16'h1)));
		end
		wait_drained();
	endtask

	task automatic run_strings(input int n_items, input int tx_idle, input int rx_stall);
		int sent;
		int kind;
		logic [15:0] u;
		tx_idle_pct = tx_idle;
		rx_stall_pct = rx_stall;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(99);
			if (kind < 8) begin
				send_word(16'($urandom), 1'b1);
				sent++;
			end else if (kind < 30) begin
				send_unit(16'($urandom_range(0, ASCII_TOP)));
				sent++;
			end else if (kind < 45) begin
				send_unit(16'($urandom_range(TWO_BYTE_FIRST, TWO_BYTE_TOP)));
				sent++;
			end else if (kind < 62) begin
				u = 16'($urandom_range(THREE_BYTE_FIRST, 16'hFFFF));
				if (u >= HIGH_FIRST && u <= HIGH_TOP) u = u ^ 16'h2000;
				send_unit(u);
				sent++;
			end else if (kind < 82) begin
				send_unit(16'($urandom_range(HIGH_FIRST, HIGH_TOP)));
				send_unit(16'($urandom_range(LOW_FIRST, LOW_TOP)));
				sent += 2;
			end else if (kind < 88) begin
				send_unit(16'($urandom_range(LOW_FIRST, LOW_TOP)));
				sent++;
			end else if (kind < 94) begin
				// broken pair: high half followed by anything
				send_unit(16'($urandom_range(HIGH_FIRST, HIGH_TOP)));
				send_word(16'($urandom), 1'($urandom));
				sent += 2;
			end else begin
				send_word(16'($urandom), 1'($urandom_range(3) == 0));
				sent++;
			end
		end
	endtask

	task automatic test_random_strings();
		run_strings(60, 0, 0);
		run_strings(60, 68, 0);
		run_strings(60, 0, 68);
		run_strings(60, 14, 14);
		send_word(16'($urandom), 1'b1);
		wait_drained();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready = 1'b0;
			hold_left--;
		end else begin
			m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (utf8_expected.size() == 0) begin
				$error("unexpected word: out_byte=%02h last_byte=%0b", m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				next_byte = utf8_expected.pop_front();
				if (m_axis_tdata !== next_byte.data) begin
					$error("out_byte: expected %02h, got %02h", next_byte.data, m_axis_tdata);
					errors++;
				end
				if (m_axis_tlast !== next_byte.last) begin
					$error("last_byte: expected %0b, got %0b", next_byte.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		held_high = '0;
		high_held = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_left = 0;
		errors = 0;
		cycle_count = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_single_units();
		test_surrogates();
		test_string_end();
		test_input_stall();
		test_random_strings();

		if (utf8_expected.size() != 0) begin
			$error("%0d expected bytes never arrived", utf8_expected.size());
			errors++;
		end
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
